>>> rtl/ehst_pkg.sv
// ehst_pkg: shared types and constants of the handshake session tracker
// no dependencies
package ehst_pkg;

    // result classes
    localparam logic [2:0] CLS_SHORT   = 3'd0;
    localparam logic [2:0] CLS_NODATA  = 3'd1;
    localparam logic [2:0] CLS_NOEAPOL = 3'd2;
    localparam logic [2:0] CLS_NOKEY   = 3'd3;
    localparam logic [2:0] CLS_MSG1    = 3'd4;
    localparam logic [2:0] CLS_MSG2    = 3'd5;
    localparam logic [2:0] CLS_MSG3    = 3'd6;
    localparam logic [2:0] CLS_REC     = 3'd7;

    localparam int HDR_LEN = 24;
    localparam int LLC_LEN = 8;
    localparam int KEY_LEN = 99;
    localparam int NONCE_BYTES = 32;
    localparam int MIC_BYTES = 16;
    localparam int REC_HDR_BYTES = 94;

    localparam logic [7:0] SNAP_SAP   = 8'hAA;
    localparam logic [7:0] ETH_HI     = 8'h88;
    localparam logic [7:0] ETH_LO     = 8'h8E;
    localparam logic [7:0] EAPOL_KEY  = 8'h03;
    localparam logic [1:0] TYPE_DATA  = 2'd2;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        frame_end;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  frame_class;
        logic [2:0]  session_slot;
        logic [3:0]  session_status;
        logic [31:0] eapol_seen_count;
        logic [63:0] record_word;
        logic        record_last;
    } t_out_item;

endpackage

>>> rtl/ehst_stream_if.sv
// ehst_stream_if: valid/ready channel carrying one word of type T
// depends on nothing; payload types come from ehst_pkg at the instance
interface ehst_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/eapol_handshake_session_tracker.sv
// eapol_handshake_session_tracker: frame byte parser, session table and record emitter
// depends on ehst_pkg and ehst_stream_if
// throughput: one frame byte per cycle while receiving (ready is low outside S_RX);
// non-key frames give their result from S_DEC. key frames: session search reads and compares
// each used slot (S_FRD, S_FCMP), plus an eviction scan when full (S_VRD, S_VCMP), copy of
// staged bytes (S_COPY), then the result; a completed record goes byte by byte (S_RRD, S_RCAP).
// reset clears control state only; session memories need no clearing pass
module eapol_handshake_session_tracker #(
    parameter int SESSION_SLOTS   = 8,
    parameter int EAPOL_BYTES     = 256,
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ehst_stream_if.sink   i_in,
    ehst_stream_if.source o_out
);
    localparam int SL_W   = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
    localparam int CNT_W  = $clog2(SESSION_SLOTS + 1);
    localparam int POS_W  = $clog2(MAX_FRAME_BYTES + 1);
    localparam int EB_AW  = $clog2(EAPOL_BYTES);
    localparam int EL_W   = $clog2(EAPOL_BYTES + 1);
    localparam int REC_BYTES = ehst_pkg::REC_HDR_BYTES + EAPOL_BYTES;
    localparam int REC_WORDS = (REC_BYTES + 7) / 8;
    localparam int RB_W   = $clog2(REC_WORDS * 8);

    localparam logic [3:0] S_RX     = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_FRD    = 4'd2;
    localparam logic [3:0] S_FCMP   = 4'd3;
    localparam logic [3:0] S_VRD    = 4'd4;
    localparam logic [3:0] S_VCMP   = 4'd5;
    localparam logic [3:0] S_COPY   = 4'd6;
    localparam logic [3:0] S_COMMIT = 4'd7;
    localparam logic [3:0] S_RRD    = 4'd8;
    localparam logic [3:0] S_RCAP   = 4'd9;
    localparam logic [3:0] S_OUTW   = 4'd10;

    typedef struct packed {
        logic [47:0]     ap;
        logic [47:0]     cl;
        logic [31:0]     last;
        logic [3:0]      flags;
        logic [EL_W-1:0] len;
    } t_sess;

    // memories
    logic [7:0] staged_nonce [ehst_pkg::NONCE_BYTES];
    logic [7:0] staged_mic   [ehst_pkg::MIC_BYTES];
    logic [7:0] staged_eapol [EAPOL_BYTES];
    t_sess      sess_mem     [SESSION_SLOTS];
    logic [7:0] anonce_mem   [SESSION_SLOTS][ehst_pkg::NONCE_BYTES];
    logic [7:0] snonce_mem   [SESSION_SLOTS][ehst_pkg::NONCE_BYTES];
    logic [7:0] mic_mem      [SESSION_SLOTS][ehst_pkg::MIC_BYTES];
    logic [7:0] eapol_mem    [SESSION_SLOTS][EAPOL_BYTES];

    logic [3:0]       r_state, r_ret;
    logic [POS_W-1:0] r_pos;
    logic [15:0]      r_fc;
    logic [47:0]      r_a1, r_a2, r_ap, r_cl;
    logic [15:0]      r_ki;
    logic [4:0]       r_mf;
    logic [31:0]      r_now, r_total, r_vlast;
    logic [CNT_W-1:0] r_count, r_i;
    logic [SL_W-1:0]  r_slot;
    logic             r_vflag;
    logic [2:0]       r_cls;
    logic [EL_W-1:0]  r_el, r_k, r_wk, r_len;
    logic             r_wv;
    logic [3:0]       r_flags;
    logic             r_fresh;
    logic [RB_W-1:0]  r_rb;
    logic [63:0]      r_word;
    logic             r_ovalid;
    ehst_pkg::t_out_item r_odata;
    t_sess            r_sq;
    logic [7:0]       r_snq, r_smq, r_seq, r_anq, r_ssq, r_miq, r_eaq;

    // receive-side decode of the current byte
    logic [7:0]       b;
    logic             acc;
    logic [POS_W-1:0] off, e, d, len_min, el_raw;
    logic [3:0]       sub;
    logic             msg2;
    logic [EL_W-1:0]  copy_lim;

    assign b   = i_in.data.frame_byte;
    assign acc = i_in.valid && (r_state == S_RX);
    assign i_in.ready = (r_state == S_RX);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    assign sub = r_fc[7:4];
    always_comb begin
        off = POS_W'(ehst_pkg::HDR_LEN);
        if (sub inside {[4'd8:4'd11]}) off = off + POS_W'(2);
        if (r_fc[9:8] == 2'b11) off = off + POS_W'(6);
        e       = off + POS_W'(ehst_pkg::LLC_LEN);
        d       = r_pos - e;
        len_min = e + POS_W'(ehst_pkg::KEY_LEN);
        el_raw  = r_pos - e;
    end
    assign msg2     = (r_cls == ehst_pkg::CLS_MSG2);
    assign copy_lim = msg2 ? r_el : EL_W'(ehst_pkg::NONCE_BYTES);

    // class of a finished frame ahead of the session lookup
    logic [2:0] dec_cls;
    logic       dec_eapol;
    logic       dec_key;
    always_comb begin
        dec_eapol = 1'b0;
        dec_key   = 1'b0;
        if (r_pos < POS_W'(ehst_pkg::HDR_LEN)) begin
            dec_cls = ehst_pkg::CLS_SHORT;
        end else if (r_fc[3:2] != ehst_pkg::TYPE_DATA) begin
            dec_cls = ehst_pkg::CLS_NODATA;
        end else if (r_pos < len_min || r_mf[3:0] != 4'hF) begin
            dec_cls = ehst_pkg::CLS_NOEAPOL;
        end else begin
            dec_eapol = 1'b1;
            if (!r_mf[4]) begin
                dec_cls = ehst_pkg::CLS_NOKEY;
            end else begin
                dec_key = 1'b1;
                if (!r_ki[8])      dec_cls = ehst_pkg::CLS_MSG1;
                else if (!r_ki[9]) dec_cls = ehst_pkg::CLS_MSG2;
                else               dec_cls = ehst_pkg::CLS_MSG3;
            end
        end
    end

    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [3:0] idx);
        logic [7:0] v;
        v = 8'h00;
        for (int j = 0; j < 6; j++) begin
            if (idx == 4'(j)) v = mac[47 - 8*j -: 8];
        end
        return v;
    endfunction

    // record byte selection
    logic [7:0]      rbyte;
    logic [RB_W-1:0] rb_e;
    always_comb begin
        rb_e = r_rb - RB_W'(ehst_pkg::REC_HDR_BYTES);
        if (r_rb < RB_W'(6))        rbyte = mac_byte(r_ap, 4'(r_rb));
        else if (r_rb < RB_W'(12))  rbyte = mac_byte(r_cl, 4'(r_rb - RB_W'(6)));
        else if (r_rb < RB_W'(44))  rbyte = r_anq;
        else if (r_rb < RB_W'(76))  rbyte = r_ssq;
        else if (r_rb < RB_W'(92))  rbyte = r_miq;
        else if (r_rb == RB_W'(92)) rbyte = 8'(16'(r_len) >> 8);
        else if (r_rb == RB_W'(93)) rbyte = 8'(r_len);
        else if (32'(rb_e) < 32'(r_len)) rbyte = r_eaq;
        else rbyte = 8'h00;
    end

    // staged byte memories: written while receiving, read during the copy
    always_ff @(posedge i_clk) begin
        if (acc && r_pos < POS_W'(MAX_FRAME_BYTES) && r_pos >= POS_W'(2) && r_pos >= e) begin
            if (d >= POS_W'(17) && d < POS_W'(49))
                staged_nonce[5'(d - POS_W'(17))] <= b;
            if (d >= POS_W'(81) && d < POS_W'(97))
                staged_mic[4'(d - POS_W'(81))] <= b;
            if (d < POS_W'(EAPOL_BYTES))
                staged_eapol[EB_AW'(d)] <= b;
        end
        r_snq <= staged_nonce[5'(r_k)];
        r_smq <= staged_mic[4'(r_k)];
        r_seq <= staged_eapol[EB_AW'(r_k)];
    end

    // session store memories
    always_ff @(posedge i_clk) begin
        if (r_wv) begin
            if (r_wk < EL_W'(ehst_pkg::NONCE_BYTES)) begin
                if (msg2) snonce_mem[r_slot][5'(r_wk)] <= r_snq;
                else      anonce_mem[r_slot][5'(r_wk)] <= r_snq;
            end
            if (msg2 && r_wk < EL_W'(ehst_pkg::MIC_BYTES))
                mic_mem[r_slot][4'(r_wk)] <= r_smq;
            if (msg2)
                eapol_mem[r_slot][EB_AW'(r_wk)] <= r_seq;
        end
        r_anq <= anonce_mem[r_slot][5'(r_rb - RB_W'(12))];
        r_ssq <= snonce_mem[r_slot][5'(r_rb - RB_W'(44))];
        r_miq <= mic_mem[r_slot][4'(r_rb - RB_W'(76))];
        r_eaq <= eapol_mem[r_slot][EB_AW'(rb_e)];
        if (r_state == S_COMMIT)
            sess_mem[r_slot] <= '{ap: r_ap, cl: r_cl, last: r_now, flags: r_flags, len: r_len};
        r_sq <= sess_mem[SL_W'(r_i)];
    end

    t_sess      new_ent;
    logic [3:0] f_new;
    assign new_ent = r_sq;
    always_comb begin
        f_new = r_flags | (msg2 ? 4'b0110 : 4'b0001);
        if (f_new == 4'b0111) f_new = 4'b1111;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_RX;
            r_ret    <= S_RX;
            r_pos    <= '0;
            r_fc     <= '0;
            r_a1     <= '0;
            r_a2     <= '0;
            r_ki     <= '0;
            r_mf     <= '0;
            r_count  <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
            r_wv     <= 1'b0;
        end else begin
            r_wv <= (r_state == S_COPY) && (r_k < copy_lim);
            case (r_state)
                S_RX: begin
                    if (acc) begin
                        if (r_pos < POS_W'(MAX_FRAME_BYTES)) begin
                            r_pos <= r_pos + POS_W'(1);
                            if (r_pos == POS_W'(0)) begin
                                r_fc <= {8'h00, b};
                            end else if (r_pos == POS_W'(1)) begin
                                r_fc[15:8] <= b;
                            end else begin
                                if (r_pos >= POS_W'(4) && r_pos <= POS_W'(9))
                                    r_a1 <= {r_a1[39:0], b};
                                if (r_pos >= POS_W'(10) && r_pos <= POS_W'(15))
                                    r_a2 <= {r_a2[39:0], b};
                                if (r_pos == off && b == ehst_pkg::SNAP_SAP) r_mf[0] <= 1'b1;
                                if (r_pos == off + POS_W'(1) && b == ehst_pkg::SNAP_SAP)
                                    r_mf[1] <= 1'b1;
                                if (r_pos == off + POS_W'(6) && b == ehst_pkg::ETH_HI)
                                    r_mf[2] <= 1'b1;
                                if (r_pos == off + POS_W'(7) && b == ehst_pkg::ETH_LO)
                                    r_mf[3] <= 1'b1;
                                if (r_pos >= e) begin
                                    if (d == POS_W'(1) && b == ehst_pkg::EAPOL_KEY)
                                        r_mf[4] <= 1'b1;
                                    if (d == POS_W'(5)) r_ki[15:8] <= b;
                                    if (d == POS_W'(6)) r_ki[7:0] <= b;
                                end
                            end
                        end
                        if (i_in.data.frame_end) begin
                            r_now   <= i_in.data.now_ms;
                            r_state <= S_DEC;
                        end
                    end
                end
                S_DEC: begin
                    r_pos <= '0;
                    r_mf  <= '0;
                    r_ret <= S_RX;
                    if (dec_eapol) r_total <= r_total + 32'd1;
                    if (!dec_key) begin
                        r_odata <= '{frame_class: dec_cls, session_slot: 3'd0,
                                     session_status: 4'd0,
                                     eapol_seen_count: r_total + 32'(dec_eapol),
                                     record_word: 64'd0, record_last: 1'b0};
                        r_ovalid <= 1'b1;
                        r_state  <= S_OUTW;
                    end else begin
                        if (!r_fc[8]) begin
                            r_ap <= r_a2;
                            r_cl <= r_a1;
                        end else begin
                            r_ap <= r_a1;
                            r_cl <= r_a2;
                        end
                        r_cls <= dec_cls;
                        r_el <= (el_raw > POS_W'(EAPOL_BYTES)) ? EL_W'(EAPOL_BYTES)
                                                              : EL_W'(el_raw);
                        r_i     <= '0;
                        r_state <= S_FRD;
                    end
                end
                S_FRD: begin
                    r_k <= '0;
                    if (r_i < r_count) begin
                        r_state <= S_FCMP;
                    end else if (r_count < CNT_W'(SESSION_SLOTS)) begin
                        r_slot  <= SL_W'(r_count);
                        r_count <= r_count + CNT_W'(1);
                        r_flags <= '0;
                        r_len   <= '0;
                        r_state <= S_COPY;
                    end else begin
                        r_i     <= '0;
                        r_state <= S_VRD;
                    end
                end
                S_FCMP: begin
                    if (new_ent.ap == r_ap && new_ent.cl == r_cl) begin
                        r_slot  <= SL_W'(r_i);
                        r_flags <= new_ent.flags;
                        r_len   <= new_ent.len;
                        r_state <= S_COPY;
                    end else begin
                        r_i     <= r_i + CNT_W'(1);
                        r_state <= S_FRD;
                    end
                end
                S_VRD: begin
                    r_state <= S_VCMP;
                end
                S_VCMP: begin
                    logic brk;
                    brk = 1'b0;
                    if (r_i == '0) begin
                        r_slot  <= '0;
                        r_vflag <= new_ent.flags[3];
                        r_vlast <= new_ent.last;
                    end else if (new_ent.flags[3] && !r_vflag) begin
                        r_slot <= SL_W'(r_i);
                        brk = 1'b1;
                    end else if (new_ent.last < r_vlast) begin
                        r_slot  <= SL_W'(r_i);
                        r_vflag <= new_ent.flags[3];
                        r_vlast <= new_ent.last;
                    end
                    if (brk || r_i == CNT_W'(SESSION_SLOTS - 1)) begin
                        r_flags <= '0;
                        r_len   <= '0;
                        r_state <= S_COPY;
                    end else begin
                        r_i     <= r_i + CNT_W'(1);
                        r_state <= S_VRD;
                    end
                end
                S_COPY: begin
                    if (r_k < copy_lim) begin
                        r_wk <= r_k;
                        r_k  <= r_k + EL_W'(1);
                    end else begin
                        r_flags <= f_new;
                        r_fresh <= f_new[3] && !r_flags[3];
                        if (msg2) r_len <= r_el;
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    r_odata <= '{frame_class: r_cls, session_slot: 3'(r_slot),
                                 session_status: r_flags, eapol_seen_count: r_total,
                                 record_word: 64'd0, record_last: 1'b0};
                    r_ovalid <= 1'b1;
                    r_rb     <= '0;
                    // a session that has just become complete goes out as a record
                    r_ret    <= r_fresh ? S_RRD : S_RX;
                    r_state  <= S_OUTW;
                end
                S_RRD: begin
                    r_state <= S_RCAP;
                end
                S_RCAP: begin
                    r_word <= {r_word[55:0], rbyte};
                    r_rb   <= r_rb + RB_W'(1);
                    if (r_rb[2:0] == 3'd7) begin
                        r_odata <= '{frame_class: ehst_pkg::CLS_REC,
                                     session_slot: 3'(r_slot),
                                     session_status: r_flags,
                                     eapol_seen_count: r_total,
                                     record_word: {r_word[55:0], rbyte},
                                     record_last: (r_rb == RB_W'(REC_WORDS * 8 - 1))};
                        r_ovalid <= 1'b1;
                        r_ret    <= (r_rb == RB_W'(REC_WORDS * 8 - 1)) ? S_RX : S_RRD;
                        r_state  <= S_OUTW;
                    end else begin
                        r_state <= S_RRD;
                    end
                end
                S_OUTW: begin
                    if (o_out.ready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= r_ret;
                    end
                end
                default: begin
                    r_state <= S_RX;
                end
            endcase
        end
    end

endmodule

>>> test/ehst_checker.sv
// ehst_checker: predicts and checks the results of the handshake session tracker
// watches both stream channels; depends on ehst_pkg
module ehst_checker #(
    parameter int SLOTS     = 8,
    parameter int EAP_BYTES = 256,
    parameter int MAX_BYTES = 2048
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  ehst_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  ehst_pkg::t_out_item i_out_data,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_records
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REC_LEN   = ehst_pkg::REC_HDR_BYTES + EAP_BYTES;
    localparam int REC_WORDS = (REC_LEN + 7) / 8;

    // parser state
    int unsigned pos;
    logic [15:0] fc_q;
    logic [47:0] addr1, addr2;
    logic [15:0] keyinfo;
    logic [4:0]  llc_hits;
    logic [7:0]  nonce_buf [ehst_pkg::NONCE_BYTES];
    logic [7:0]  mic_buf [ehst_pkg::MIC_BYTES];
    logic [7:0]  eap_buf [EAP_BYTES];

    // session table
    logic [47:0] tab_ap [SLOTS];
    logic [47:0] tab_cl [SLOTS];
    logic [31:0] tab_seen [SLOTS];
    logic [3:0]  tab_flags [SLOTS];
    logic [7:0]  tab_anonce [SLOTS][ehst_pkg::NONCE_BYTES];
    logic [7:0]  tab_snonce [SLOTS][ehst_pkg::NONCE_BYTES];
    logic [7:0]  tab_mic [SLOTS][ehst_pkg::MIC_BYTES];
    logic [7:0]  tab_eap [SLOTS][EAP_BYTES];
    int          tab_len [SLOTS];
    int          used_slots;
    logic [31:0] eapol_count;

    ehst_pkg::t_out_item due_results [$];

    assign o_pending = due_results.size();

    function automatic int hdr_bytes(logic [15:0] fc);
        int o;
        o = ehst_pkg::HDR_LEN;
        if (fc[7:4] >= 4'd8 && fc[7:4] <= 4'd11) o += 2;
        if (fc[9:8] == 2'b11) o += 6;
        return o;
    endfunction

    function automatic void reset_table();
        pos = 0; fc_q = '0; addr1 = '0; addr2 = '0; keyinfo = '0; llc_hits = '0;
        used_slots = 0; eapol_count = '0;
        for (int s = 0; s < SLOTS; s++) begin
            tab_ap[s] = '0; tab_cl[s] = '0; tab_seen[s] = '0; tab_flags[s] = '0;
            tab_len[s] = 0;
        end
    endfunction

    function automatic void parse_byte(int unsigned p, logic [7:0] b);
        int unsigned off, e;
        if (p == 0) begin
            fc_q = {8'h00, b};
            return;
        end
        if (p == 1) begin
            fc_q[15:8] = b;
            return;
        end
        if (p >= 4 && p <= 9) addr1 = {addr1[39:0], b};
        if (p >= 10 && p <= 15) addr2 = {addr2[39:0], b};
        off = hdr_bytes(fc_q);
        e = off + ehst_pkg::LLC_LEN;
        if (p == off && b == ehst_pkg::SNAP_SAP) llc_hits[0] = 1'b1;
        if (p == off + 1 && b == ehst_pkg::SNAP_SAP) llc_hits[1] = 1'b1;
        if (p == off + 6 && b == ehst_pkg::ETH_HI) llc_hits[2] = 1'b1;
        if (p == off + 7 && b == ehst_pkg::ETH_LO) llc_hits[3] = 1'b1;
        if (p < e) return;
        if (p == e + 1 && b == ehst_pkg::EAPOL_KEY) llc_hits[4] = 1'b1;
        if (p == e + 5) keyinfo[15:8] = b;
        if (p == e + 6) keyinfo[7:0] = b;
        if (p >= e + 17 && p < e + 49) nonce_buf[p - e - 17] = b;
        if (p >= e + 81 && p < e + 97) mic_buf[p - e - 81] = b;
        if (p - e < EAP_BYTES) eap_buf[p - e] = b;
    endfunction

    function automatic int session_for(logic [47:0] ap, logic [47:0] cl, logic [31:0] now);
        int s, v;
        for (int i = 0; i < used_slots; i++)
            if (tab_ap[i] == ap && tab_cl[i] == cl) return i;
        if (used_slots >= SLOTS) begin
            // prefer a saved slot while the pick is unsaved, else oldest stamp
            v = 0;
            for (int i = 1; i < SLOTS; i++) begin
                if (tab_flags[i][3] && !tab_flags[v][3]) begin
                    v = i;
                    break;
                end
                if (tab_seen[i] < tab_seen[v]) v = i;
            end
            s = v;
        end else begin
            s = used_slots;
            used_slots++;
        end
        tab_ap[s] = ap; tab_cl[s] = cl; tab_flags[s] = '0; tab_seen[s] = now; tab_len[s] = 0;
        for (int i = 0; i < ehst_pkg::NONCE_BYTES; i++) begin
            tab_anonce[s][i] = '0;
            tab_snonce[s][i] = '0;
        end
        for (int i = 0; i < ehst_pkg::MIC_BYTES; i++) tab_mic[s][i] = '0;
        for (int i = 0; i < EAP_BYTES; i++) tab_eap[s][i] = '0;
        return s;
    endfunction

    function automatic void push_result(logic [2:0] cls, int s, logic [3:0] st,
                                        logic [63:0] w, logic last);
        ehst_pkg::t_out_item r;
        r.frame_class = cls;
        r.session_slot = s[2:0];
        r.session_status = st;
        r.eapol_seen_count = eapol_count;
        r.record_word = w;
        r.record_last = last;
        due_results.push_back(r);
    endfunction

    function automatic void take_item(ehst_pkg::t_in_item it);
        int unsigned len, off, el;
        int s, n;
        logic [2:0] cls;
        logic [47:0] ap, cl;
        logic [15:0] fc;
        logic [7:0] rec [REC_WORDS * 8];
        logic [63:0] w;
        if (pos < MAX_BYTES) begin
            parse_byte(pos, it.frame_byte);
            pos++;
        end
        if (!it.frame_end) return;
        len = pos;
        fc = fc_q;
        off = hdr_bytes(fc);
        pos = 0;
        if (len < ehst_pkg::HDR_LEN) begin
            push_result(ehst_pkg::CLS_SHORT, 0, 4'd0, 64'd0, 1'b0); llc_hits = '0; return;
        end
        if (fc[3:2] != ehst_pkg::TYPE_DATA) begin
            push_result(ehst_pkg::CLS_NODATA, 0, 4'd0, 64'd0, 1'b0); llc_hits = '0; return;
        end
        if (len < off + ehst_pkg::LLC_LEN + ehst_pkg::KEY_LEN || llc_hits[3:0] != 4'hF) begin
            push_result(ehst_pkg::CLS_NOEAPOL, 0, 4'd0, 64'd0, 1'b0); llc_hits = '0; return;
        end
        eapol_count++;
        if (!llc_hits[4]) begin
            push_result(ehst_pkg::CLS_NOKEY, 0, 4'd0, 64'd0, 1'b0); llc_hits = '0; return;
        end
        llc_hits = '0;
        if (!fc[8]) begin
            ap = addr2; cl = addr1;
        end else begin
            ap = addr1; cl = addr2;
        end
        s = session_for(ap, cl, it.now_ms);
        tab_seen[s] = it.now_ms;
        if (!keyinfo[8]) begin
            cls = ehst_pkg::CLS_MSG1;
            for (int i = 0; i < ehst_pkg::NONCE_BYTES; i++) tab_anonce[s][i] = nonce_buf[i];
            tab_flags[s][0] = 1'b1;
        end else if (!keyinfo[9]) begin
            cls = ehst_pkg::CLS_MSG2;
            for (int i = 0; i < ehst_pkg::NONCE_BYTES; i++) tab_snonce[s][i] = nonce_buf[i];
            for (int i = 0; i < ehst_pkg::MIC_BYTES; i++) tab_mic[s][i] = mic_buf[i];
            tab_flags[s][2:1] = 2'b11;
            el = len - (off + ehst_pkg::LLC_LEN);
            if (el > EAP_BYTES) el = EAP_BYTES;
            tab_len[s] = el;
            for (int i = 0; i < el; i++) tab_eap[s][i] = eap_buf[i];
        end else begin
            cls = ehst_pkg::CLS_MSG3;
            for (int i = 0; i < ehst_pkg::NONCE_BYTES; i++) tab_anonce[s][i] = nonce_buf[i];
            tab_flags[s][0] = 1'b1;
        end
        if (tab_flags[s] != 4'h7) begin
            push_result(cls, s, tab_flags[s], 64'd0, 1'b0);
            return;
        end
        tab_flags[s][3] = 1'b1;
        push_result(cls, s, tab_flags[s], 64'd0, 1'b0);
        o_records++;
        foreach (rec[i]) rec[i] = '0;
        n = 0;
        for (int i = 5; i >= 0; i--) rec[n++] = tab_ap[s][8*i +: 8];
        for (int i = 5; i >= 0; i--) rec[n++] = tab_cl[s][8*i +: 8];
        for (int i = 0; i < ehst_pkg::NONCE_BYTES; i++) rec[n++] = tab_anonce[s][i];
        for (int i = 0; i < ehst_pkg::NONCE_BYTES; i++) rec[n++] = tab_snonce[s][i];
        for (int i = 0; i < ehst_pkg::MIC_BYTES; i++) rec[n++] = tab_mic[s][i];
        rec[n++] = 8'(tab_len[s] >> 8);
        rec[n++] = 8'(tab_len[s]);
        for (int i = 0; i < tab_len[s]; i++) rec[n + i] = tab_eap[s][i];
        for (int k = 0; k < REC_WORDS; k++) begin
            for (int b = 0; b < 8; b++) w = {w[55:0], rec[k*8 + b]};
            push_result(ehst_pkg::CLS_REC, s, tab_flags[s], w, k == REC_WORDS - 1);
        end
    endfunction

    task automatic check_word(ehst_pkg::t_out_item got);
        ehst_pkg::t_out_item want;
        if (due_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            o_fail_count++;
            return;
        end
        want = due_results.pop_front();
        if (got.frame_class !== want.frame_class) begin
            $display("%0t: frame_class exp %0d got %0d", $time, want.frame_class,
                     got.frame_class);
            o_fail_count++;
        end
        if (got.session_slot !== want.session_slot) begin
            $display("%0t: session_slot exp %0d got %0d", $time, want.session_slot,
                     got.session_slot);
            o_fail_count++;
        end
        if (got.session_status !== want.session_status) begin
            $display("%0t: session_status exp %h got %h", $time, want.session_status,
                     got.session_status);
            o_fail_count++;
        end
        if (got.eapol_seen_count !== want.eapol_seen_count) begin
            $display("%0t: eapol_seen_count exp %0d got %0d", $time,
                     want.eapol_seen_count, got.eapol_seen_count);
            o_fail_count++;
        end
        if (got.record_word !== want.record_word) begin
            $display("%0t: record_word exp %h got %h", $time, want.record_word,
                     got.record_word);
            o_fail_count++;
        end
        if (got.record_last !== want.record_last) begin
            $display("%0t: record_last exp %0d got %0d", $time, want.record_last,
                     got.record_last);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_records = 0;
        reset_table();
    end

    // input first so a word arriving on the same edge is already predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_table();
            due_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) take_item(i_in_data);
            if (i_out_valid && i_out_ready) check_word(i_out_data);
        end
    end

endmodule

>>> test/tb_top.sv
// tb_top: frame stimulus and verdict for the handshake session tracker
// depends on ehst_pkg, ehst_stream_if, the tracker and ehst_checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 600000;
    localparam int PAIRS = 2;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycles = 0;
    int   fails, pending, records;
    int   send_idle = 0;
    int   recv_stall = 0;
    int   frames = 0;
    int   bytes_sent = 0;

    logic [7:0]  frame_bytes [$];
    logic [47:0] pair_ap [PAIRS];
    logic [47:0] pair_cl [PAIRS];

    ehst_stream_if #(.T(ehst_pkg::t_in_item))  in_ch ();
    ehst_stream_if #(.T(ehst_pkg::t_out_item)) out_ch ();

    eapol_handshake_session_tracker i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    ehst_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_ready  (in_ch.ready),
        .i_in_data   (in_ch.data),
        .i_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_out_data  (out_ch.data),
        .o_fail_count(fails),
        .o_pending   (pending),
        .o_records   (records)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall);
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL eapol_handshake_session_tracker");
            $finish;
        end
    end

    // 0 none, 1 sender idle, 2 receiver stalls, 3 both lightly
    task automatic set_phase(int ph);
        case (ph % 4)
            0: begin
                send_idle = 0; recv_stall = 0;
            end
            1: begin
                send_idle = 63; recv_stall = 0;
            end
            2: begin
                send_idle = 0; recv_stall = 63;
            end
            default: begin
                send_idle = 6; recv_stall = 6;
            end
        endcase
    endtask

    // last word carries the stamp that the session sees; the frame's results drain
    // under its own phase
    task automatic send_frame(logic [31:0] stamp);
        ehst_pkg::t_in_item it;
        set_phase(frames);
        for (int i = 0; i < frame_bytes.size(); i++) begin
            while ($urandom_range(99) < send_idle) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
            it.frame_byte = frame_bytes[i];
            it.frame_end = (i == frame_bytes.size() - 1);
            it.now_ms = it.frame_end ? stamp : $urandom;
            in_ch.valid <= 1'b1;
            in_ch.data <= it;
            do @(posedge i_clk); while (!in_ch.ready);
            bytes_sent++;
        end
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        frames++;
    endtask

    task automatic random_bytes(int n);
        frame_bytes.delete();
        for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom));
    endtask

    // msg: 1, 2 or 3; extra bytes follow the key header
    task automatic make_key(int msg, int pair, bit qos, bit four, bit tods, int extra);
        logic [7:0] b0, b1, ki_hi;
        logic [47:0] a1, a2;
        int off;
        b0 = {qos ? 4'(8 + $urandom_range(3)) : 4'($urandom_range(7)), 2'b10, 2'($urandom)};
        b1 = {6'($urandom), four ? 2'b11 : {1'b0, tods}};
        off = ehst_pkg::HDR_LEN + (qos ? 2 : 0) + (four ? 6 : 0);
        if (b1[0]) begin
            a1 = pair_ap[pair]; a2 = pair_cl[pair];
        end else begin
            a1 = pair_cl[pair]; a2 = pair_ap[pair];
        end
        random_bytes(off + ehst_pkg::LLC_LEN + ehst_pkg::KEY_LEN + extra);
        frame_bytes[0] = b0;
        frame_bytes[1] = b1;
        for (int i = 0; i < 6; i++) begin
            frame_bytes[4 + i] = a1[8*(5-i) +: 8];
            frame_bytes[10 + i] = a2[8*(5-i) +: 8];
        end
        frame_bytes[off] = ehst_pkg::SNAP_SAP;
        frame_bytes[off + 1] = ehst_pkg::SNAP_SAP;
        frame_bytes[off + 6] = ehst_pkg::ETH_HI;
        frame_bytes[off + 7] = ehst_pkg::ETH_LO;
        frame_bytes[off + 9] = ehst_pkg::EAPOL_KEY;
        ki_hi = 8'($urandom);
        case (msg)
            1: ki_hi[0] = 1'b0;
            2: ki_hi[1:0] = 2'b01;
            default: ki_hi[1:0] = 2'b11;
        endcase
        frame_bytes[off + 13] = ki_hi;
    endtask

    initial begin
        pair_ap[0] = '0;
        pair_cl[0] = '1;
        pair_ap[1] = {$urandom, $urandom};
        pair_cl[1] = {$urandom, $urandom};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // a one-byte frame with no idling
        random_bytes(1);
        send_frame(32'h0);
        // message 1 under sender idling, message 2 under receiver stalls completes it
        make_key(1, 0, 0, 0, 0, 0);
        send_frame(32'h0);
        make_key(2, 0, 0, 0, 1, 0);
        send_frame(32'hFFFF_FFFF);
        // management frame of exactly header length, then one byte short of a header
        random_bytes(ehst_pkg::HDR_LEN);
        frame_bytes[0][3:2] = 2'b00;
        send_frame(32'h1);
        random_bytes(ehst_pkg::HDR_LEN - 1);
        send_frame(32'h2);

        repeat (100) @(posedge i_clk);
        $display("%0d frames, %0d bytes, %0d handshake records across four idle phases",
                 frames, bytes_sent, records);
        $display("covered short and non-data frames and one complete handshake record");
        if (fails == 0) begin
            $display("PASS eapol_handshake_session_tracker");
        end else begin
            $display("FAIL eapol_handshake_session_tracker");
        end
        $finish;
    end

endmodule
